[design/nsl_pkg.sv]
// Shared types and constants for the non-decreasing subsequence length engine.
package nsl_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TAG_W    = 20;
  localparam int unsigned LEN_W    = 11;

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        query_tag;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] chain_length;
    logic [TAG_W-1:0] tag_out;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_PROBE  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

[design/nsl_engine.sv]
// Tail table memory and binary search / update sequencer.
module nsl_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  nsl_pkg::in_t     item,
  input  logic             res_ready,
  output nsl_pkg::res_t    res,
  output nsl_pkg::status_t status
);

  logic signed [nsl_pkg::KEY_W-1:0] mem [nsl_pkg::CAPACITY];
  logic signed [nsl_pkg::KEY_W-1:0] rd_data;

  nsl_pkg::state_t           state, state_next;
  nsl_pkg::in_t              cur;
  logic [nsl_pkg::CNT_W-1:0] lo, lo_next;
  logic [nsl_pkg::CNT_W-1:0] hi, hi_next;
  logic [nsl_pkg::CNT_W-1:0] mid, mid_next;
  logic [nsl_pkg::CNT_W-1:0] count, count_next;

  logic                      gt;
  logic [nsl_pkg::CNT_W-1:0] lo_step, hi_step, span;
  logic                      rd_en, wr_en;
  logic [nsl_pkg::CNT_W-1:0] rd_pos, wr_pos;

  // one probe per cycle: compare the returned tail, narrow, launch next read
  assign gt      = $signed(rd_data) > $signed(cur.key);
  assign lo_step = gt ? lo : mid + nsl_pkg::CNT_W'(1);
  assign hi_step = gt ? mid : hi;
  assign span    = hi_step - lo_step;

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    count_next = count;
    rd_en      = 1'b0;
    rd_pos     = mid;
    wr_en      = 1'b0;
    wr_pos     = lo;
    res.valid  = 1'b0;
    res.data.chain_length = nsl_pkg::LEN_W'(lo);
    res.data.tag_out      = cur.query_tag;
    unique case (state)
      nsl_pkg::S_IDLE: begin
        if (start) begin
          lo_next  = '0;
          hi_next  = count;
          mid_next = count >> 1;
          if (count != '0) begin
            rd_en      = 1'b1;
            rd_pos     = count >> 1;
            state_next = nsl_pkg::S_PROBE;
          end else begin
            state_next = nsl_pkg::S_FINISH;
          end
        end
      end
      nsl_pkg::S_PROBE: begin
        lo_next = lo_step;
        hi_next = hi_step;
        if (lo_step < hi_step) begin
          mid_next = lo_step + (span >> 1);
          rd_en    = 1'b1;
          rd_pos   = lo_step + (span >> 1);
        end else begin
          state_next = nsl_pkg::S_FINISH;
        end
      end
      nsl_pkg::S_FINISH: begin
        if (cur.command == nsl_pkg::CMD_QUERY) begin
          res.valid = 1'b1;
          if (res_ready) begin
            state_next = nsl_pkg::S_IDLE;
          end
        end else begin
          // append when nothing is greater, drop if full; otherwise replace
          if (lo >= count) begin
            wr_pos = count;
            if (count < nsl_pkg::CNT_W'(nsl_pkg::CAPACITY)) begin
              wr_en      = 1'b1;
              count_next = count + nsl_pkg::CNT_W'(1);
            end
          end else begin
            wr_en = 1'b1;
          end
          state_next = nsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nsl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsl_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == nsl_pkg::S_IDLE && start) begin
      cur <= item;
    end
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
  end

  // reads and writes never overlap: writes only happen after the search ends
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_pos[nsl_pkg::ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_pos[nsl_pkg::ADDR_W-1:0]] <= cur.key;
    end
  end

  assign status.busy  = (state != nsl_pkg::S_IDLE);
  assign status.count = count;

endmodule

[design/nondecreasing_subseq_length_query.sv]
// Top level: request channel, search engine and registered result stage.
// An item passes the idle, probe and finish states, with P binary search probes over the tail table
// (0 when empty, at most 11 with 1024 tails): one probe per cycle on the memory read port.
// The next request is taken only once the engine is idle.
// Query results are registered from the finish state; a stalled result holds the engine.
// Synchronous reset empties the table (count to zero); tail memory is not cleared.
module nondecreasing_subseq_length_query (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  nsl_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output nsl_pkg::out_t result
);

  nsl_pkg::res_t    res;
  nsl_pkg::status_t status;
  logic             res_ready;
  logic             start;

  assign item_stall = status.busy;
  assign start      = item_valid && !item_stall;
  assign res_ready  = !result_valid || !result_stall;

  nsl_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .res_ready (res_ready),
    .res       (res),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      result <= res.data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= nsl_pkg::CNT_W'(nsl_pkg::CAPACITY))
    else $error("tail count above capacity");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (status.count == $past(status.count)) ||
             (status.count == $past(status.count) + nsl_pkg::CNT_W'(1)))
    else $error("tail count moved by more than one");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> status.busy)
    else $error("engine idle after taking a request");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> nsl_pkg::CNT_W'(result.chain_length) <= status.count)
    else $error("chain length above tail count");

endmodule
